// ===== design/ddc_pkg.sv =====
// Shared types, constants and register map of the disparity-to-depth converter.
package ddc_pkg;

	localparam int DEF_COUNT_WIDTH = 24;
	localparam int DEF_FRAC_BITS   = 16;

	localparam int NUM_W    = 48;
	localparam int QUO_BITS = 16;
	localparam int STEP_W   = $clog2(QUO_BITS);
	localparam int TOTAL_W  = 24;
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = 6;

	localparam logic [14:0] DEPTH_SAT     = 15'h7FFF;
	localparam logic [14:0] MAX_DEPTH_RST = 15'h7FFF;

	localparam logic [2:0] REG_FIELD_LAYOUT  = 3'd0;
	localparam logic [2:0] REG_DISP_WINDOW   = 3'd1;
	localparam logic [2:0] REG_CONF_THRESH   = 3'd2;
	localparam logic [2:0] REG_MAX_DEPTH     = 3'd3;
	localparam logic [2:0] REG_INVALID_VALUE = 3'd4;
	localparam logic [2:0] REG_OUTPUT_SHIFTS = 3'd5;
	localparam logic [2:0] REG_DEPTH_NUM     = 3'd6;
	localparam logic [2:0] REG_DEN_OFFSET    = 3'd7;

	typedef struct packed {
		logic [15:0] raw_word;
		logic        frame_last;
	} src_beat_t;

	typedef struct packed {
		logic [15:0]        out_word;
		logic               pixel_invalid;
		logic [TOTAL_W-1:0] invalid_total;
		logic               frame_end;
	} res_beat_t;

	typedef struct packed {
		logic [39:0]        field_layout;
		logic [31:0]        disparity_window;
		logic [14:0]        confidence_threshold;
		logic [14:0]        max_depth;
		logic [15:0]        invalid_value;
		logic [7:0]         output_shifts;
		logic [NUM_W-1:0]   depth_numerator;
		logic signed [31:0] denominator_offset;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP1,
		ST_PREP2,
		ST_DIV,
		ST_ROUND,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic prep1;
		logic prep2;
		logic div_step;
		logic round;
		logic finish;
	} dp_cmd_t;

endpackage

// ===== design/ddc_regs.sv =====
// APB-style configuration register file.
module ddc_regs import ddc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.field_layout         <= '0;
			cfg_q.disparity_window     <= '0;
			cfg_q.confidence_threshold <= '0;
			cfg_q.max_depth            <= MAX_DEPTH_RST;
			cfg_q.invalid_value        <= '0;
			cfg_q.output_shifts        <= '0;
			cfg_q.depth_numerator      <= '0;
			cfg_q.denominator_offset   <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FIELD_LAYOUT:  cfg_q.field_layout         <= pwdata[39:0];
				REG_DISP_WINDOW:   cfg_q.disparity_window     <= pwdata[31:0];
				REG_CONF_THRESH:   cfg_q.confidence_threshold <= pwdata[14:0];
				REG_MAX_DEPTH:     cfg_q.max_depth            <= pwdata[14:0];
				REG_INVALID_VALUE: cfg_q.invalid_value        <= pwdata[15:0];
				REG_OUTPUT_SHIFTS: cfg_q.output_shifts        <= pwdata[7:0];
				REG_DEPTH_NUM:     cfg_q.depth_numerator      <= pwdata[NUM_W-1:0];
				REG_DEN_OFFSET:    cfg_q.denominator_offset   <= $signed(pwdata[31:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FIELD_LAYOUT:  prdata = DATA_W'(cfg_q.field_layout);
			REG_DISP_WINDOW:   prdata = DATA_W'(cfg_q.disparity_window);
			REG_CONF_THRESH:   prdata = DATA_W'(cfg_q.confidence_threshold);
			REG_MAX_DEPTH:     prdata = DATA_W'(cfg_q.max_depth);
			REG_INVALID_VALUE: prdata = DATA_W'(cfg_q.invalid_value);
			REG_OUTPUT_SHIFTS: prdata = DATA_W'(cfg_q.output_shifts);
			REG_DEPTH_NUM:     prdata = DATA_W'(cfg_q.depth_numerator);
			REG_DEN_OFFSET:    prdata = DATA_W'(unsigned'(cfg_q.denominator_offset));
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== design/ddc_ctrl.sv =====
// Sequencing state machine: input handshake, divider step count, result valid.
module ddc_ctrl import ddc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    src_valid,
	output logic    src_stall,
	output logic    res_valid,
	input  logic    res_stall,
	output dp_cmd_t cmd
);

	ctrl_state_t       state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              res_valid_q;
	logic              out_free;
	logic              step_last;

	assign out_free  = !res_valid_q || !res_stall;
	assign step_last = (step_q == STEP_W'(QUO_BITS - 1));
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (src_valid) state_d = ST_PREP1;
			ST_PREP1:  state_d = ST_PREP2;
			ST_PREP2:  state_d = ST_DIV;
			ST_DIV:    if (step_last) state_d = ST_ROUND;
			ST_ROUND:  state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		src_stall    = (state_q != ST_IDLE);
		cmd.load     = (state_q == ST_IDLE) && src_valid;
		cmd.prep1    = (state_q == ST_PREP1);
		cmd.prep2    = (state_q == ST_PREP2);
		cmd.div_step = (state_q == ST_DIV);
		cmd.round    = (state_q == ST_ROUND);
		cmd.finish   = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/ddc_dpath.sv =====
// Datapath: field extraction, denominator, radix-2 divider, rounding, packing, count.
module ddc_dpath import ddc_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  dp_cmd_t   cmd,
	input  src_beat_t src_beat,
	output res_beat_t res_beat
);

	localparam int SUM_SH_W = 16 + FRAC_BITS;
	localparam int DEN_W    = ((SUM_SH_W > 31) ? SUM_SH_W : 31) + 2;
	localparam int DVS_W    = DEN_W - 1 + QUO_BITS - 1;
	localparam int DIV_W    = (NUM_W > DVS_W) ? NUM_W : DVS_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// Captured input beat
	logic [15:0] raw_q;
	logic        last_q;

	// Extracted fields
	logic [15:0] disp_s1, conf_s1;

	// Denominator and divider state
	logic                 sum_zero_q, nonpos_q;
	logic [DEN_W-2:0]     den_q;
	logic [DIV_W-1:0]     rem_q, dvs_q;
	logic [QUO_BITS-1:0]  quo_q;
	logic [14:0]          depth_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	res_beat_t            res_q;

	// Combinational
	logic [15:0] dmask, cmask, dmax, foff, limit, disp_raw, conf_raw, sum_v;
	logic [3:0]  dsh, csh, ocsh, odsh;
	logic signed [DEN_W-1:0] den_v;
	logic [DIV_W:0]          diff_v;
	logic [DEN_W-1:0]        rem2_v, den_ext_v;
	logic                    round_up;
	logic [15:0]             qr_v;
	logic                    keep_depth;
	logic [15:0]             code_v;
	logic                    inval_v;
	logic [COUNT_WIDTH-1:0]  cnt_new;

	assign dmask = cfg.field_layout[15:0];
	assign dsh   = cfg.field_layout[19:16];
	assign cmask = cfg.field_layout[35:20];
	assign csh   = cfg.field_layout[39:36];
	assign dmax  = cfg.disparity_window[15:0];
	assign foff  = cfg.disparity_window[31:16];
	assign ocsh  = cfg.output_shifts[3:0];
	assign odsh  = cfg.output_shifts[7:4];

	assign limit    = dmax + foff;
	assign disp_raw = (raw_q & dmask) >> dsh;
	assign conf_raw = (raw_q & cmask) >> csh;

	assign sum_v = disp_s1 + foff;
	assign den_v = $signed(DEN_W'({sum_v, {FRAC_BITS{1'b0}}})) +
		DEN_W'(cfg.denominator_offset);

	assign diff_v = {1'b0, rem_q} - {1'b0, dvs_q};

	// Round half to even on the final remainder
	assign rem2_v    = {rem_q[DEN_W-2:0], 1'b0};
	assign den_ext_v = {1'b0, den_q};
	assign round_up  = (rem2_v > den_ext_v) || ((rem2_v == den_ext_v) && quo_q[0]);
	assign qr_v      = {1'b0, quo_q[14:0]} + 16'(round_up);

	assign keep_depth = (depth_q < cfg.max_depth) && (disp_s1 != 16'd0) &&
		(conf_s1 >= {1'b0, cfg.confidence_threshold});
	assign code_v  = keep_depth ? {1'b0, depth_q} : cfg.invalid_value;
	assign inval_v = (code_v == cfg.invalid_value);
	assign cnt_new = (inval_v && (cnt_q != CNT_MAX)) ? cnt_q + 1'b1 : cnt_q;

	assign res_beat = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q  <= src_beat.raw_word;
			last_q <= src_beat.frame_last;
		end
		if (cmd.prep1) begin
			disp_s1 <= (disp_raw >= limit) ? 16'd0 : disp_raw;
			conf_s1 <= conf_raw;
		end
		if (cmd.prep2) begin
			sum_zero_q <= (sum_v == 16'd0);
			nonpos_q   <= den_v[DEN_W-1] || (den_v == '0);
			den_q      <= den_v[DEN_W-2:0];
			rem_q      <= DIV_W'(cfg.depth_numerator);
			dvs_q      <= DIV_W'({den_v[DEN_W-2:0], {(QUO_BITS-1){1'b0}}});
			quo_q      <= '0;
		end
		if (cmd.div_step) begin
			if (!diff_v[DIV_W]) begin
				rem_q <= diff_v[DIV_W-1:0];
			end
			quo_q <= {quo_q[QUO_BITS-2:0], !diff_v[DIV_W]};
			dvs_q <= dvs_q >> 1;
		end
		if (cmd.round) begin
			if (sum_zero_q) begin
				depth_q <= '0;
			end else if (nonpos_q || quo_q[QUO_BITS-1] || qr_v[15]) begin
				depth_q <= DEPTH_SAT;
			end else begin
				depth_q <= qr_v[14:0];
			end
		end
		if (cmd.finish) begin
			res_q.out_word      <= (conf_s1 >> ocsh) | (code_v << odsh);
			res_q.pixel_invalid <= inval_v;
			res_q.invalid_total <= TOTAL_W'(cnt_new);
			res_q.frame_end     <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.finish) begin
			cnt_q <= last_q ? '0 : cnt_new;
		end
	end

endmodule

// ===== design/disparity_to_depth_converter_core.sv =====
// Top level of the disparity-to-depth converter: registers, controller and datapath.
//
// Each accepted pixel beat yields one result beat. Each pixel goes through one
// capture step, two set-up steps (field extraction and windowing, then the
// fixed-point denominator), 16 steps of a radix-2 restoring divider that
// shares one wide subtractor, one rounding step and one packing step that
// writes the result register before the next pixel is accepted. The result
// register parts the two channels, so the next pixel is taken while a
// finished result still waits; only when the previous result has not been
// taken by the end of the packing step does the block hold there.
// The numerator is unsigned Q32.16 and the denominator offset signed Q16.16
// (FRAC_BITS fraction bits); depth is rounded half to even and saturated to
// 32767, and a zero disparity sum gives depth 0. The invalid count saturates
// and clears after the beat that carries frame_last. Configuration sits on an
// APB-style port with 64-bit data, register i at byte address 8*i; the user
// must write it only while no pixel is in flight, which the block does not enforce.
module disparity_to_depth_converter_core import ddc_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	// Pixel channel
	input  logic              src_valid,
	output logic              src_stall,
	input  src_beat_t         src_beat,
	// Result channel
	output logic              res_valid,
	input  logic              res_stall,
	output res_beat_t         res_beat,
	// Configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t    cfg;
	dp_cmd_t cmd;

	// Hold configuration; reads return the stored value
	ddc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequence one pixel at a time and own the result valid flag
	ddc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd)
	);

	// Extract, divide, round, pack and count
	ddc_dpath #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.src_beat (src_beat),
		.res_beat (res_beat)
	);

endmodule

// ===== design/ddc_checker.sv =====
// Port-level checker for the disparity-to-depth converter, with its bind.
module ddc_checker import ddc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      src_valid,
	input logic      src_stall,
	input logic      res_valid,
	input logic      res_stall,
	input res_beat_t res_beat
);

	// A stalled result beat stays offered and unchanged
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_beat))
		else $error("stalled result beat changed or dropped");

	// One pixel at a time: the block is busy right after taking a beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> src_stall)
		else $error("pixel channel open right after accepting a beat");

	// An invalid pixel is counted, so its running total cannot read zero
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_beat.pixel_invalid |-> res_beat.invalid_total != '0)
		else $error("invalid pixel reported with zero invalid total");

	// A new result is not yet offered when the taken pixel reaches its second set-up step
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall && !res_valid |=> ##1 !res_valid)
		else $error("result appeared before the divider could finish");

endmodule

bind disparity_to_depth_converter_core ddc_checker u_ddc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_beat  (res_beat)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the disparity-to-depth converter core.
module tb;
	import ddc_pkg::*;

	localparam int LONG_HOLD      = 400;   // receiver hold-off that fills the block
	localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transfer
	localparam int SETTLE_CYCLES  = 25;    // covers the time one pixel spends in the block
	localparam int RANDOM_PHASES  = 4;
	localparam int PHASE_PIXELS   = 110;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              src_valid = 1'b0;
	logic              src_stall;
	src_beat_t         src_beat  = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	res_beat_t         res_beat;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Shadow copy of the register file and the per-frame invalid count
	cfg_t                      shadow_cfg;
	logic [DEF_COUNT_WIDTH-1:0] invalid_count;
	res_beat_t                 pending_depth_q[$];

	int mismatch_count = 0;
	int stuck_cycles   = 0;

	// Idling controls: the test side sets them, the channel processes read them
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int hold_req   = 0;   // bumped by a test to ask for one long hold-off
	int hold_seen  = 0;
	int hold_left  = 0;
	int rx_burst   = 0;

	disparity_to_depth_converter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_beat  (src_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #10 clk = ~clk;

	// Compute the result beat of one pixel from the shadow registers and
	// advance the invalid count the same way the block does.
	function automatic res_beat_t predict_depth_beat(input src_beat_t px);
		logic [15:0] disp, conf, limit, sum;
		logic [31:0] depth, word;
		longint      den;
		logic [63:0] quo, rem, dvs;
		logic        inval;
		res_beat_t   res;
		disp  = (px.raw_word & shadow_cfg.field_layout[15:0]) >> shadow_cfg.field_layout[19:16];
		conf  = (px.raw_word & shadow_cfg.field_layout[35:20]) >> shadow_cfg.field_layout[39:36];
		// Window limit and denominator sum both wrap at 16 bits
		limit = shadow_cfg.disparity_window[15:0] + shadow_cfg.disparity_window[31:16];
		if (disp >= limit)
			disp = '0;
		sum = disp + shadow_cfg.disparity_window[31:16];
		if (sum == '0) begin
			depth = '0;
		end else begin
			den = (longint'(sum) <<< DEF_FRAC_BITS)
				+ longint'($signed(shadow_cfg.denominator_offset));
			if (den <= 0) begin
				depth = 32'(DEPTH_SAT);
			end else begin
				dvs = 64'(den);
				quo = {16'd0, shadow_cfg.depth_numerator} / dvs;
				rem = {16'd0, shadow_cfg.depth_numerator} % dvs;
				// Round half to even
				if ((rem << 1) > dvs || ((rem << 1) == dvs && quo[0]))
					quo = quo + 64'd1;
				depth = (quo > 64'(DEPTH_SAT)) ? 32'(DEPTH_SAT) : quo[31:0];
			end
		end
		if (depth >= 32'(shadow_cfg.max_depth) || disp == '0 ||
		    conf < 16'(shadow_cfg.confidence_threshold))
			depth = 32'(shadow_cfg.invalid_value);
		// A good depth that happens to equal the code counts as invalid too
		inval = (depth == 32'(shadow_cfg.invalid_value));
		if (inval && invalid_count != '1)
			invalid_count = invalid_count + 1'b1;
		word = (32'(conf) >> shadow_cfg.output_shifts[3:0]) |
			(depth << shadow_cfg.output_shifts[7:4]);
		res.out_word      = word[15:0];
		res.pixel_invalid = inval;
		res.invalid_total = invalid_count[TOTAL_W-1:0];
		res.frame_end     = px.frame_last;
		if (px.frame_last)
			invalid_count = '0;
		return res;
	endfunction

	// Compare one taken result beat against the oldest pending prediction
	function automatic void check_depth_beat(input res_beat_t got);
		res_beat_t want;
		if (pending_depth_q.size() == 0) begin
			$error("result beat %h arrived with no pixel pending", got);
			mismatch_count++;
			return;
		end
		want = pending_depth_q.pop_front();
		if (got.out_word !== want.out_word) begin
			$error("out_word: expected %h, got %h", want.out_word, got.out_word);
			mismatch_count++;
		end
		if (got.pixel_invalid !== want.pixel_invalid) begin
			$error("pixel_invalid: expected %b, got %b", want.pixel_invalid, got.pixel_invalid);
			mismatch_count++;
		end
		if (got.invalid_total !== want.invalid_total) begin
			$error("invalid_total: expected %0d, got %0d", want.invalid_total, got.invalid_total);
			mismatch_count++;
		end
		if (got.frame_end !== want.frame_end) begin
			$error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
			mismatch_count++;
		end
	endfunction

	// Result side: check every taken beat, then pick the stall for the next
	// cycle. A requested hold-off wins over everything, random stall bursts
	// come next, and with idling off the stall stays low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				check_depth_beat(res_beat);
			if (hold_left != 0) begin
				res_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_seen != hold_req) begin
				res_stall <= 1'b1;
				hold_left <= LONG_HOLD - 1;
				hold_seen <= hold_seen + 1;
			end else if (!rx_idle_en) begin
				res_stall <= 1'b0;
			end else if (rx_burst != 0) begin
				res_stall <= 1'b1;
				rx_burst  <= rx_burst - 1;
			end else if ($urandom_range(0, 3) == 0) begin
				res_stall <= 1'b1;
				rx_burst  <= $urandom_range(0, 9);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run when no beat and no register access moves for too long
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (res_valid && !res_stall) || psel) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Write one register over the config port; keep the shadow copy in step.
	// Return only once psel has been sampled low, so psel is never dropped and
	// raised in the same step.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_FIELD_LAYOUT:  shadow_cfg.field_layout         = value[39:0];
			REG_DISP_WINDOW:   shadow_cfg.disparity_window     = value[31:0];
			REG_CONF_THRESH:   shadow_cfg.confidence_threshold = value[14:0];
			REG_MAX_DEPTH:     shadow_cfg.max_depth            = value[14:0];
			REG_INVALID_VALUE: shadow_cfg.invalid_value        = value[15:0];
			REG_OUTPUT_SHIFTS: shadow_cfg.output_shifts        = value[7:0];
			REG_DEPTH_NUM:     shadow_cfg.depth_numerator      = value[NUM_W-1:0];
			REG_DEN_OFFSET:    shadow_cfg.denominator_offset   = value[31:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one pixel beat and hold it until taken; then maybe drop valid
	// for a random gap. Valid stays high into the next call otherwise.
	task automatic send_pixel(input logic [15:0] raw, input logic last);
		src_beat_t px;
		px.raw_word   = raw;
		px.frame_last = last;
		src_valid <= 1'b1;
		src_beat  <= px;
		do @(posedge clk); while (src_stall);
		pending_depth_q.push_back(predict_depth_beat(px));
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// Stop offering pixels until every predicted result has been taken,
	// then let the block settle so it is idle for register writes
	task automatic wait_drained();
		src_valid <= 1'b0;
		while (pending_depth_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Load a random setting. Styles 0 and 1 keep disparities and the
	// numerator in a range where most depths land inside the valid window;
	// the other style draws the layout, window, numerator and offset at random.
	task automatic program_random_setup(input int style);
		logic [15:0] dmask, cmask, dmax, foff;
		logic [3:0]  dsh, csh;
		logic [47:0] num;
		logic [31:0] offs;
		case (style)
			0: begin
				dmask = 16'h00FF; dsh = 4'd0; cmask = 16'hFF00; csh = 4'd8;
			end
			1: begin
				dmask = 16'hFFF0; dsh = 4'd4; cmask = 16'h000F; csh = 4'd0;
			end
			default: begin
				dmask = 16'($urandom); dsh = 4'($urandom);
				cmask = 16'($urandom); csh = 4'($urandom);
			end
		endcase
		if (style < 2) begin
			dmax = 16'($urandom_range(8, 4095));
			foff = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
			num  = {32'($urandom_range(1, 3000000)), 16'($urandom)};
			offs = 32'($urandom_range(0, 262144)) - 32'd131072;
		end else begin
			dmax = 16'($urandom);
			foff = 16'($urandom);
			num  = {16'($urandom), 32'($urandom)};
			offs = 32'($urandom);
		end
		// Junk above the register width must be ignored
		write_reg(REG_FIELD_LAYOUT, {24'($urandom), csh, cmask, dsh, dmask});
		write_reg(REG_DISP_WINDOW, {32'($urandom), foff, dmax});
		write_reg(REG_CONF_THRESH, ($urandom_range(0, 3) == 0) ?
			64'($urandom_range(0, 32767)) : 64'($urandom_range(0, 3)));
		write_reg(REG_MAX_DEPTH, 64'($urandom_range(100, 32767)));
		write_reg(REG_INVALID_VALUE, 64'($urandom_range(0, 65535)));
		write_reg(REG_OUTPUT_SHIFTS, 64'($urandom_range(0, 255)));
		write_reg(REG_DEPTH_NUM, {16'd0, num});
		write_reg(REG_DEN_OFFSET, {32'd0, offs});
	endtask

	// Reset setting: empty masks zero every disparity, so all pixels are invalid
	task automatic test_reset_values();
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'($urandom), 1'b1);
		send_pixel(16'($urandom), 1'b0);
	endtask

	// Hand-picked pixels: window edges, confidence edge, rounding ties both
	// ways, a good depth equal to the invalid code, non-positive denominator,
	// saturation and a disparity sum that wraps to zero
	task automatic test_directed_cases();
		wait_drained();
		write_reg(REG_FIELD_LAYOUT, {24'd0, 4'd8, 16'hFF00, 4'd0, 16'h00FF});
		write_reg(REG_DISP_WINDOW, {32'd0, 16'd0, 16'd200});
		write_reg(REG_CONF_THRESH, 64'd16);
		write_reg(REG_MAX_DEPTH, 64'd30000);
		write_reg(REG_INVALID_VALUE, 64'hFFFF);
		write_reg(REG_OUTPUT_SHIFTS, 64'h00);
		write_reg(REG_DEPTH_NUM, 64'd163840);    // 2.5 in Q32.16
		write_reg(REG_DEN_OFFSET, 64'd0);
		send_pixel(16'h8001, 1'b0);   // 2.5 ties down to 2
		send_pixel(16'h8005, 1'b0);   // 0.5 ties down to 0
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hFFFF, 1'b0);   // above the window
		send_pixel(16'h40C7, 1'b0);   // just below the limit
		send_pixel(16'h40C8, 1'b0);   // at the limit
		send_pixel(16'h0F03, 1'b0);   // confidence one below threshold
		send_pixel(16'h1003, 1'b1);   // confidence at threshold, frame ends
		wait_drained();
		write_reg(REG_DEPTH_NUM, 64'd229376);    // 3.5 in Q32.16
		write_reg(REG_INVALID_VALUE, 64'd4);
		send_pixel(16'h8001, 1'b0);   // 3.5 ties up to 4, equal to the code
		send_pixel(16'h8007, 1'b0);
		send_pixel(16'h8002, 1'b0);
		wait_drained();
		write_reg(REG_DEPTH_NUM, 64'hFFFF_FFFF_FFFF);
		write_reg(REG_DEN_OFFSET, {32'd0, 32'hFFFE_0000});   // -2.0
		send_pixel(16'h8001, 1'b0);   // negative denominator
		send_pixel(16'h8002, 1'b0);   // zero denominator
		send_pixel(16'h8003, 1'b1);   // quotient far above saturation
		wait_drained();
		write_reg(REG_DISP_WINDOW, {32'd0, 16'hFFFF, 16'd100});
		write_reg(REG_DEN_OFFSET, 64'd0);
		write_reg(REG_DEPTH_NUM, 64'd229376);
		write_reg(REG_INVALID_VALUE, 64'hFFFF);
		send_pixel(16'h8001, 1'b0);   // sum wraps to zero, depth 0
		send_pixel(16'h8002, 1'b0);
		send_pixel(16'h8063, 1'b0);   // limit wrapped down to 99
		send_pixel(16'hFFFF, 1'b1);
	endtask

	// All-ones words, widest and narrowest values, extreme offsets
	task automatic test_register_extremes();
		wait_drained();
		write_reg(REG_FIELD_LAYOUT, '1);
		write_reg(REG_DISP_WINDOW, '1);
		write_reg(REG_CONF_THRESH, '1);
		write_reg(REG_MAX_DEPTH, '1);
		write_reg(REG_INVALID_VALUE, '1);
		write_reg(REG_OUTPUT_SHIFTS, '1);
		write_reg(REG_DEPTH_NUM, '1);
		write_reg(REG_DEN_OFFSET, '1);
		repeat (8) send_pixel(16'($urandom), 1'($urandom));
		wait_drained();
		write_reg(REG_FIELD_LAYOUT, {24'd0, 4'd0, 16'hFFFF, 4'd0, 16'hFFFF});
		write_reg(REG_DISP_WINDOW, {32'd0, 16'd0, 16'hFFFF});
		write_reg(REG_CONF_THRESH, 64'd0);
		write_reg(REG_MAX_DEPTH, 64'h7FFF);
		write_reg(REG_INVALID_VALUE, 64'd0);
		write_reg(REG_OUTPUT_SHIFTS, 64'd0);
		write_reg(REG_DEPTH_NUM, 64'hFFFF_FFFF_FFFF);
		write_reg(REG_DEN_OFFSET, {32'd0, 32'h7FFF_FFFF});
		repeat (8) send_pixel(16'($urandom), 1'($urandom));
		wait_drained();
		write_reg(REG_MAX_DEPTH, 64'd0);
		write_reg(REG_OUTPUT_SHIFTS, 64'hF0);
		write_reg(REG_DEPTH_NUM, 64'd0);
		write_reg(REG_DEN_OFFSET, {32'd0, 32'h8000_0000});
		repeat (6) send_pixel(16'($urandom), 1'($urandom));
	endtask

	// Random pixel streams under several settings; pause halfway through each
	// phase until every result is back. Phase 1 turns off idling on the pixel
	// side and phase 2 on the result side, to leave stretches without gaps.
	task automatic test_random_phases();
		int p, n;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			program_random_setup(p % 3);
			tx_idle_en = (p != 1);
			rx_idle_en = (p != 2);
			for (n = 0; n < PHASE_PIXELS; n++) begin
				if (n == PHASE_PIXELS / 2)
					wait_drained();
				send_pixel(16'($urandom), $urandom_range(0, 15) == 0);
			end
		end
	endtask

	// Hold the result side off for a long stretch while pixels keep coming,
	// so the result register fills and the block stalls its input
	task automatic test_backpressure();
		int n;
		wait_drained();
		program_random_setup(0);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		hold_req++;
		for (n = 0; n < 40; n++)
			send_pixel(16'($urandom), n == 39);
		wait_drained();
	endtask

	// Closing stream with no idling on either side
	task automatic test_steady_stream();
		int n;
		wait_drained();
		program_random_setup(1);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		for (n = 0; n < 40; n++)
			send_pixel(16'($urandom), n % 10 == 9);
		wait_drained();
	endtask

	initial begin
		// Shadow registers start at their reset values
		shadow_cfg           = '0;
		shadow_cfg.max_depth = MAX_DEPTH_RST;
		invalid_count        = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed_cases();
		test_register_extremes();
		test_random_phases();
		test_backpressure();
		test_steady_stream();
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
